### sv/sha1_pkg.sv
// SHA-1 package: round constants, initial chain value, controller/datapath structs.
// Used by the controller, datapath and top level.
`timescale 1ns / 1ps
package sha1_pkg;
   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hEFCDAB89;
   localparam logic [31:0] H2 = 32'h98BADCFE;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hC3D2E1F0;
   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam int unsigned LEN_POS = 56;

   // byte source for the buffer write
   localparam logic [1:0] SRC_DATA = 2'd0;
   localparam logic [1:0] SRC_PAD  = 2'd1;
   localparam logic [1:0] SRC_ZERO = 2'd2;
   localparam logic [1:0] SRC_LEN  = 2'd3;

   typedef struct packed {
      logic       wr_en;       // write one byte at byte_count
      logic [1:0] wr_src;
      logic [7:0] wr_data;
      logic       len_add;     // add 8 to bit count
      logic       round_start; // load working regs, begin 80 rounds
      logic       round_step;
      logic       chain_fold;  // add working regs into chain
      logic       msg_clear;   // chain to IV, counters to zero
      logic       out_load;    // load digest word from chain
      logic [2:0] out_index;
   } sha1_cmd_type;

   typedef struct packed {
      logic [5:0] byte_count;
      logic [6:0] round_cnt;
   } sha1_status_type;
endpackage

### sv/sha1_hash_engine.sv
// SHA-1 engine top level: joins controller and datapath.
// Depends on sha1_pkg, sha1_ctrl, sha1_datapath.
//
// Input channel req_*: one transaction per item carries an optional byte
// (req_byte_valid) and an end-of-message mark. A byte that completes a
// 64-byte block starts 80 rounds at one per cycle and then a fold, and
// req_stall stays high until the fold is done; other bytes that do not end the message raise no stall.
// On end of message the block writes 0x80 and zero/length bytes one a cycle
// to the block end, then runs one compression. When the 0x80 lands past
// byte 55, a second zero/length block and compression follow. After the
// last fold, word 0 is loaded into the output register and shown on rsp_*
// (word 0 first, rsp_last_word on word 4), then one word per cycle while
// rsp_stall is low. A stalled word holds. Once word 4 is taken the chain
// value and counts return to the initial value and the input reopens.
// Reset (synchronous, active high) clears control state and loads the
// initial chain value; no clearing pass is needed.
`timescale 1ns / 1ps
module sha1_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   sha1_pkg::sha1_cmd_type    cmd;
   sha1_pkg::sha1_status_type status;

   sha1_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_data_byte, .req_byte_valid,
      .req_end_of_message, .rsp_valid, .rsp_stall, .rsp_word_index,
      .rsp_last_word, .cmd, .status
   );

   sha1_datapath u_dp (
      .clock, .reset, .cmd, .status, .out_word(rsp_digest_word)
   );
endmodule

### sv/sha1_datapath.sv
// SHA-1 datapath: block buffer, message schedule window, round logic, chain value.
// Depends on sha1_pkg.
`timescale 1ns / 1ps
module sha1_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  sha1_pkg::sha1_cmd_type    cmd,
   output sha1_pkg::sha1_status_type status,
   output logic [31:0]               out_word
);
   logic [31:0] w_ff [16];
   logic [31:0] h_ff [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] len_ff;
   logic [6:0]  rnd_ff;
   logic [7:0]  wbyte;
   logic [31:0] f, k, tmp, wnew, wcur;
   logic [2:0]  lsel;

   assign status.byte_count = cnt_ff;
   assign status.round_cnt  = rnd_ff;

   assign lsel = 3'(3'd7 - cnt_ff[2:0]);
   always_comb begin
      case (cmd.wr_src)
         sha1_pkg::SRC_DATA: wbyte = cmd.wr_data;
         sha1_pkg::SRC_PAD:  wbyte = sha1_pkg::PAD_BYTE;
         sha1_pkg::SRC_ZERO: wbyte = 8'h00;
         sha1_pkg::SRC_LEN:  wbyte = 8'(len_ff >> {lsel, 3'b000});
         default:            wbyte = 8'h00;
      endcase
   end

   // w_ff[0] is the current round word; window shifts each round
   assign wnew = {w_ff[13][30:0] ^ w_ff[8][30:0] ^ w_ff[2][30:0] ^ w_ff[0][30:0],
                  w_ff[13][31] ^ w_ff[8][31] ^ w_ff[2][31] ^ w_ff[0][31]};
   assign wcur = w_ff[0];

   always_comb begin
      if (rnd_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff); k = sha1_pkg::K0;
      end else if (rnd_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff; k = sha1_pkg::K1;
      end else if (rnd_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff); k = sha1_pkg::K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff; k = sha1_pkg::K3;
      end
   end
   assign tmp = {a_ff[26:0], a_ff[31:27]} + e_ff + wcur + k + f;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         // bytes enter the window big-endian at word cnt/4
         case (cnt_ff[1:0])
            2'd0: w_ff[cnt_ff[5:2]][31:24] <= wbyte;
            2'd1: w_ff[cnt_ff[5:2]][23:16] <= wbyte;
            2'd2: w_ff[cnt_ff[5:2]][15:8]  <= wbyte;
            default: w_ff[cnt_ff[5:2]][7:0] <= wbyte;
         endcase
      end else if (cmd.round_step) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= wnew;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.round_start) begin
         a_ff <= h_ff[0]; b_ff <= h_ff[1]; c_ff <= h_ff[2];
         d_ff <= h_ff[3]; e_ff <= h_ff[4];
      end else if (cmd.round_step) begin
         e_ff <= d_ff; d_ff <= c_ff; c_ff <= {b_ff[1:0], b_ff[31:2]};
         b_ff <= a_ff; a_ff <= tmp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_ff <= '0;
         cnt_ff <= '0;
         len_ff <= '0;
         h_ff[0] <= sha1_pkg::H0; h_ff[1] <= sha1_pkg::H1; h_ff[2] <= sha1_pkg::H2;
         h_ff[3] <= sha1_pkg::H3; h_ff[4] <= sha1_pkg::H4;
      end else begin
         if (cmd.round_start) rnd_ff <= '0;
         else if (cmd.round_step) rnd_ff <= rnd_ff + 7'd1;
         if (cmd.wr_en) cnt_ff <= cnt_ff + 6'd1;
         if (cmd.len_add) len_ff <= len_ff + 64'd8;
         if (cmd.chain_fold) begin
            h_ff[0] <= h_ff[0] + a_ff; h_ff[1] <= h_ff[1] + b_ff;
            h_ff[2] <= h_ff[2] + c_ff; h_ff[3] <= h_ff[3] + d_ff;
            h_ff[4] <= h_ff[4] + e_ff;
         end
         if (cmd.msg_clear) begin
            cnt_ff <= '0;
            len_ff <= '0;
            h_ff[0] <= sha1_pkg::H0; h_ff[1] <= sha1_pkg::H1; h_ff[2] <= sha1_pkg::H2;
            h_ff[3] <= sha1_pkg::H3; h_ff[4] <= sha1_pkg::H4;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) out_word <= h_ff[cmd.out_index];
   end
endmodule

### sv/sha1_ctrl.sv
// SHA-1 controller: accepts bytes, sequences compression, padding and digest output.
// Depends on sha1_pkg.
`timescale 1ns / 1ps
module sha1_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_byte_valid,
   input  logic                      req_end_of_message,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_word_index,
   output logic                      rsp_last_word,
   output sha1_pkg::sha1_cmd_type    cmd,
   input  sha1_pkg::sha1_status_type status
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ROUND = 3'd1;
   localparam logic [2:0] ST_FOLD  = 3'd2;
   localparam logic [2:0] ST_PAD   = 3'd3;
   localparam logic [2:0] ST_FILL  = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       fin_ff, fin_in;     // padding still to start after this block
   logic       lenb_ff, lenb_in;   // current fill block carries the length
   logic       ext_ff, ext_in;     // length goes into one more zero block
   logic [2:0] idx_ff, idx_in;
   logic       rv_ff, rv_in;
   logic       acc, out_take;

   assign req_stall = (state_ff != ST_IDLE);
   assign acc       = req_valid && !req_stall;
   assign rsp_valid = rv_ff;
   assign rsp_word_index = idx_ff;
   assign rsp_last_word  = (idx_ff == 3'd4);
   assign out_take = rv_ff && !rsp_stall;

   always_comb begin
      cmd = '0;
      cmd.wr_data = req_data_byte;
      state_in = state_ff; fin_in = fin_ff; lenb_in = lenb_ff; ext_in = ext_ff;
      idx_in = idx_ff; rv_in = rv_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (req_byte_valid) begin
                  cmd.wr_en = 1'b1; cmd.wr_src = sha1_pkg::SRC_DATA;
                  cmd.len_add = 1'b1;
               end
               if (req_byte_valid && status.byte_count == 6'd63) begin
                  cmd.round_start = 1'b1; state_in = ST_ROUND;
                  fin_in = req_end_of_message;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            if (status.round_cnt == 7'd79) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.chain_fold = 1'b1;
            if (lenb_ff) begin
               state_in = ST_OUT; lenb_in = 1'b0; idx_in = '0;
            end else if (fin_ff) begin
               state_in = ST_PAD; fin_in = 1'b0;
            end else if (ext_ff) begin
               state_in = ST_FILL; lenb_in = 1'b1; ext_in = 1'b0;
            end else state_in = ST_IDLE;
         end
         ST_PAD: begin
            // 0x80 then zero fill; extra block if past the length field
            cmd.wr_en = 1'b1; cmd.wr_src = sha1_pkg::SRC_PAD;
            lenb_in = (status.byte_count < 6'(sha1_pkg::LEN_POS));
            if (status.byte_count == 6'd63) begin
               cmd.round_start = 1'b1; state_in = ST_ROUND;
               ext_in = 1'b1;
            end else state_in = ST_FILL;
         end
         ST_FILL: begin
            cmd.wr_en = 1'b1;
            cmd.wr_src = (lenb_ff && status.byte_count >= 6'(sha1_pkg::LEN_POS))
                         ? sha1_pkg::SRC_LEN : sha1_pkg::SRC_ZERO;
            if (status.byte_count == 6'd63) begin
               cmd.round_start = 1'b1; state_in = ST_ROUND;
               // block without length goes on to a length block
               if (!lenb_ff) ext_in = 1'b1;
            end
         end
         ST_OUT: begin
            if (!rv_ff) begin
               cmd.out_load = 1'b1; cmd.out_index = idx_ff;
               rv_in = 1'b1;
            end else if (out_take) begin
               if (idx_ff == 3'd4) begin
                  cmd.msg_clear = 1'b1; state_in = ST_IDLE;
               end else begin
                  cmd.out_load = 1'b1; cmd.out_index = idx_ff + 3'd1;
                  rv_in = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (out_take && rv_ff) idx_in = idx_ff + 3'd1;
      if (state_ff == ST_FOLD && lenb_ff) idx_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; fin_ff <= 1'b0; lenb_ff <= 1'b0; ext_ff <= 1'b0;
         idx_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; fin_ff <= fin_in; lenb_ff <= lenb_in; ext_ff <= ext_in;
         idx_ff <= idx_in; rv_ff <= rv_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> idx_ff <= 3'd4)
      else $error("digest index out of range");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> !cmd.wr_en)
      else $error("buffer write during rounds");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && status.round_cnt != 7'd79) |=> state_ff == ST_ROUND)
      else $error("round sequence cut short");
endmodule

### test/sha1_digest_checker.sv
// Digest checker for sha1_hash_engine: watches the req_/rsp_ channels, computes SHA-1
// digests of the accepted bytes and compares each digest word. Depends on sha1_pkg.
`timescale 1ns / 1ps
module sha1_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_digest_word,
   input  logic [2:0]  rsp_word_index,
   input  logic        rsp_last_word,
   output int          mismatch_count,
   output int          pending_words
);
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   logic [31:0] chain [5];
   logic [7:0]  msg_block [64];
   int unsigned fill;
   logic [63:0] msg_bits;
   digest_word_type expected_words[$];

   assign pending_words = expected_words.size();

   function automatic logic [31:0] rol(input logic [31:0] x, input int r);
      return (x << r) | (x >> (32 - r));
   endfunction

   task automatic fold_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, t;
      int s;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int r = 0; r < 80; r++) begin
         s = r & 15;
         if (r >= 16)
            w[s] = rol(w[(s+13)&15] ^ w[(s+8)&15] ^ w[(s+2)&15] ^ w[s], 1);
         if (r < 20) begin f = (b & c) | (~b & d); k = sha1_pkg::K0; end
         else if (r < 40) begin f = b ^ c ^ d; k = sha1_pkg::K1; end
         else if (r < 60) begin f = (b & c) | (b & d) | (c & d); k = sha1_pkg::K2; end
         else begin f = b ^ c ^ d; k = sha1_pkg::K3; end
         t = rol(a, 5) + e + w[s] + k + f;
         e = d; d = c; c = rol(b, 30); b = a; a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
   endtask

   task automatic restart_message();
      chain[0] = sha1_pkg::H0; chain[1] = sha1_pkg::H1; chain[2] = sha1_pkg::H2;
      chain[3] = sha1_pkg::H3; chain[4] = sha1_pkg::H4;
      fill = 0;
      msg_bits = '0;
   endtask

   task automatic absorb_transaction(input logic [7:0] b, input logic bv, input logic eom);
      digest_word_type dw;
      if (bv) begin
         msg_block[fill] = b;
         fill++;
         msg_bits += 64'd8;
         if (fill == 64) begin
            fold_block();
            fill = 0;
         end
      end
      if (!eom) return;
      msg_block[fill] = sha1_pkg::PAD_BYTE;
      for (int i = fill + 1; i < 64; i++) msg_block[i] = 8'h00;
      if (fill + 1 > sha1_pkg::LEN_POS) begin
         fold_block();
         for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) msg_block[63-i] = msg_bits[8*i +: 8];
      fold_block();
      for (int i = 0; i < 5; i++) begin
         dw.word = chain[i];
         dw.index = 3'(i);
         dw.last = (i == 4);
         expected_words.push_back(dw);
      end
      restart_message();
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch: %s got %h expected %h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      digest_word_type exp_w;
      if (reset) begin
         mismatch_count = 0;
         restart_message();
         expected_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0)
               report_mismatch("unexpected digest word", rsp_digest_word, 32'h0);
            else begin
               exp_w = expected_words.pop_front();
               if (rsp_digest_word !== exp_w.word)
                  report_mismatch("digest_word", rsp_digest_word, exp_w.word);
               if (rsp_word_index !== exp_w.index)
                  report_mismatch("word_index", 32'(rsp_word_index), 32'(exp_w.index));
               if (rsp_last_word !== exp_w.last)
                  report_mismatch("last_word", 32'(rsp_last_word), 32'(exp_w.last));
            end
         end
         if (req_valid && !req_stall)
            absorb_transaction(req_data_byte, req_byte_valid, req_end_of_message);
      end
   end
endmodule

### test/sha1_hash_engine_tb.sv
// Testbench top for sha1_hash_engine: drives byte transactions and response stalls,
// gives the verdict. Depends on sha1_hash_engine and sha1_digest_checker.
`timescale 1ns / 1ps
module sha1_hash_engine_tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 0;
   logic        req_byte_valid = 0;
   logic        req_end_of_message = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;
   int          mismatch_count, pending_words;
   int          send_idle_pct = 0, recv_stall_pct = 0;
   longint      cycle_count = 0;

   localparam longint CYCLE_LIMIT = 2_000_000;

   always #1 clock = ~clock;

   sha1_hash_engine dut (.*);
   sha1_digest_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // one transaction; idle cycles at the chosen rate, held payload while stalled
   task automatic send_item(input logic [7:0] b, input logic bv, input logic eom);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data_byte <= b;
      req_byte_valid <= bv;
      req_end_of_message <= eom;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_message(input int len, input logic trailing_eom_only);
      for (int i = 0; i < len; i++)
         send_item(8'($urandom), 1'b1, (!trailing_eom_only && i == len - 1));
      if (trailing_eom_only || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty message, extremes, empty items
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h5A, 1'b0, 1'b0);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hA5, 1'b1, 1'b0);
      send_item(8'h3C, 1'b0, 1'b1);
      drain();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         for (int m = 0; m < 3; m++) begin
            if ($urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            if (m < 2)
               send_message(int'($urandom_range(6)), 1'($urandom_range(1)));
            else begin
               // padding boundaries: length fits, extra block, 0x80 at the
               // last byte, full block then end of message
               case (phase)
                  0: send_message(55, 1'b0);
                  1: send_message(56, 1'b0);
                  2: send_message(63, 1'b1);
                  default: send_message(64, 1'b0);
               endcase
            end
         end
         drain();
      end
      recv_stall_pct = 0;
      while (pending_words != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && pending_words == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
